FILE: design/vrot_pkg.sv
// package: widths, pipeline payload type and series reciprocal constants
`timescale 1ns / 1ps
package vrot_pkg;

  localparam int SERIES_TERMS_DEF = 9;
  localparam int VEC_W            = 16;
  localparam int ANG_W            = 16;
  localparam int A_W              = ANG_W + 3;
  localparam int A2_W             = 21;
  localparam int FRAC_W           = 16;
  localparam int TERM_W           = 24;
  localparam int SUM_W            = 26;
  localparam int RECIP_W          = 32;
  localparam int PROD_W           = TERM_W + A2_W + 1;
  localparam int MID_W            = PROD_W - FRAC_W;
  localparam int MUL_W            = MID_W + RECIP_W + 1;
  localparam int ROT_W            = VEC_W + SUM_W;
  localparam int ROT_SUM_W        = ROT_W + 1;
  localparam int ROT_SH_W         = ROT_SUM_W - FRAC_W;
  localparam logic signed [TERM_W-1:0] ONE_Q16 = TERM_W'(65536);
  localparam logic signed [VEC_W-1:0]  SAT_MAX = 16'sh7fff;
  localparam logic signed [VEC_W-1:0]  SAT_MIN = 16'sh8000;

  typedef struct packed {
    logic signed [VEC_W-1:0]  vx;
    logic signed [VEC_W-1:0]  vy;
    logic [A2_W-1:0]          a2;
    logic signed [TERM_W-1:0] s_term;
    logic signed [TERM_W-1:0] c_term;
    logic signed [SUM_W-1:0]  s_sum;
    logic signed [SUM_W-1:0]  c_sum;
  } vrot_data_t;

  // floor(2^32 / ((2k)(2k+1)))
  function automatic logic [RECIP_W-1:0] sin_recip(input int k);
    logic [RECIP_W-1:0] r;
    case (k)
      1:       r = 32'd715827882;
      2:       r = 32'd214748364;
      3:       r = 32'd102261126;
      4:       r = 32'd59652323;
      5:       r = 32'd39045157;
      6:       r = 32'd27531841;
      7:       r = 32'd20452225;
      8:       r = 32'd15790320;
      9:       r = 32'd12558383;
      10:      r = 32'd10226112;
      default: r = 32'd8488077;
    endcase
    return r;
  endfunction

  // floor(2^32 / ((2k-1)(2k)))
  function automatic logic [RECIP_W-1:0] cos_recip(input int k);
    logic [RECIP_W-1:0] r;
    case (k)
      1:       r = 32'd2147483648;
      2:       r = 32'd357913941;
      3:       r = 32'd143165576;
      4:       r = 32'd76695844;
      5:       r = 32'd47721858;
      6:       r = 32'd32537631;
      7:       r = 32'd23598721;
      8:       r = 32'd17895697;
      9:       r = 32'd14035840;
      10:      r = 32'd11302545;
      default: r = 32'd9296466;
    endcase
    return r;
  endfunction

endpackage

FILE: design/vrot_if.sv
// request channel interfaces for vectors in and rotated vectors out
`timescale 1ns / 1ps
interface vrot_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] vec_x;
  logic signed [15:0] vec_y;
  logic signed [15:0] angle;
  modport source (output valid, vec_x, vec_y, angle, input ready);
  modport sink   (input valid, vec_x, vec_y, angle, output ready);
endinterface

interface vrot_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] rot_x;
  logic signed [15:0] rot_y;
  logic               saturated;
  modport source (output valid, rot_x, rot_y, saturated, input ready);
  modport sink   (input valid, rot_x, rot_y, saturated, output ready);
endinterface

FILE: design/vrot_prep.sv
// first stage: angle scaling, angle squared and series seeds
`timescale 1ns / 1ps
module vrot_prep import vrot_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    v_in,
  output logic                    r_in,
  input  logic signed [VEC_W-1:0] vx,
  input  logic signed [VEC_W-1:0] vy,
  input  logic signed [ANG_W-1:0] ang,
  output logic                    v_out,
  input  logic                    r_out,
  output vrot_data_t              d_out
);
  logic signed [A_W-1:0]   a;
  logic signed [2*A_W-1:0] aa;

  assign a    = {ang, 3'b000};
  assign aa   = a * a;
  assign r_in = !v_out || r_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (r_in) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (r_in) begin
      d_out.vx     <= vx;
      d_out.vy     <= vy;
      d_out.a2     <= aa[A2_W+FRAC_W-1:FRAC_W];
      d_out.s_term <= TERM_W'(a);
      d_out.c_term <= ONE_Q16;
      d_out.s_sum  <= SUM_W'(a);
      d_out.c_sum  <= SUM_W'(ONE_Q16);
    end
  end
endmodule

FILE: design/vrot_term.sv
// one series step for sine and cosine: multiply by a2, then by reciprocal and accumulate
`timescale 1ns / 1ps
module vrot_term import vrot_pkg::*; #(
  parameter int K = 1
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       v_in,
  output logic       r_in,
  input  vrot_data_t d_in,
  output logic       v_out,
  input  logic       r_out,
  output vrot_data_t d_out
);
  localparam logic [RECIP_W-1:0] RS = sin_recip(K);
  localparam logic [RECIP_W-1:0] RC = cos_recip(K);

  logic                     v1;
  logic                     r2;
  vrot_data_t               d1;
  logic signed [PROD_W-1:0] ps;
  logic signed [PROD_W-1:0] pc;
  logic signed [MID_W-1:0]  ms;
  logic signed [MID_W-1:0]  mc;
  logic signed [RECIP_W:0]  rs;
  logic signed [RECIP_W:0]  rc;
  logic signed [MUL_W-1:0]  qs;
  logic signed [MUL_W-1:0]  qc;
  logic signed [MUL_W-1:0]  ns;
  logic signed [MUL_W-1:0]  nc;
  logic signed [TERM_W-1:0] ts;
  logic signed [TERM_W-1:0] tc;

  assign r2   = !v_out || r_out;
  assign r_in = !v1 || r2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v_out <= 1'b0;
    end else begin
      if (r_in) begin
        v1 <= v_in;
      end
      if (r2) begin
        v_out <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r_in) begin
      d1 <= d_in;
      ps <= d_in.s_term * $signed({1'b0, d_in.a2});
      pc <= d_in.c_term * $signed({1'b0, d_in.a2});
    end
  end

  always_comb begin
    ms = ps[PROD_W-1:FRAC_W];
    mc = pc[PROD_W-1:FRAC_W];
    rs = {1'b0, RS};
    rc = {1'b0, RC};
    qs = ms * rs;
    qc = mc * rc;
    ns = -(qs >>> RECIP_W);
    nc = -(qc >>> RECIP_W);
    ts = ns[TERM_W-1:0];
    tc = nc[TERM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (r2) begin
      d_out.vx     <= d1.vx;
      d_out.vy     <= d1.vy;
      d_out.a2     <= d1.a2;
      d_out.s_term <= ts;
      d_out.c_term <= tc;
      d_out.s_sum  <= d1.s_sum + SUM_W'(ts);
      d_out.c_sum  <= d1.c_sum + SUM_W'(tc);
    end
  end
endmodule

FILE: design/vrot_out.sv
// rotation products, combine, scale and saturate into the output register
`timescale 1ns / 1ps
module vrot_out import vrot_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       v_in,
  output logic       r_in,
  input  vrot_data_t d_in,
  vrot_out_if.source dst
);
  logic                        v1;
  logic                        r2;
  logic signed [ROT_W-1:0]     pxc;
  logic signed [ROT_W-1:0]     pys;
  logic signed [ROT_W-1:0]     pxs;
  logic signed [ROT_W-1:0]     pyc;
  logic signed [ROT_SUM_W-1:0] sx;
  logic signed [ROT_SUM_W-1:0] sy;
  logic signed [ROT_SH_W-1:0]  hx;
  logic signed [ROT_SH_W-1:0]  hy;
  logic signed [VEC_W-1:0]     ox;
  logic signed [VEC_W-1:0]     oy;
  logic                        cx;
  logic                        cy;

  assign r2   = !dst.valid || dst.ready;
  assign r_in = !v1 || r2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      dst.valid <= 1'b0;
    end else begin
      if (r_in) begin
        v1 <= v_in;
      end
      if (r2) begin
        dst.valid <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r_in) begin
      pxc <= d_in.vx * d_in.c_sum;
      pys <= d_in.vy * d_in.s_sum;
      pxs <= d_in.vx * d_in.s_sum;
      pyc <= d_in.vy * d_in.c_sum;
    end
  end

  always_comb begin
    sx = ROT_SUM_W'(pxc) - ROT_SUM_W'(pys);
    sy = ROT_SUM_W'(pxs) + ROT_SUM_W'(pyc);
    hx = sx[ROT_SUM_W-1:FRAC_W];
    hy = sy[ROT_SUM_W-1:FRAC_W];
    cx = 1'b1;
    cy = 1'b1;
    if (hx > ROT_SH_W'(SAT_MAX)) begin
      ox = SAT_MAX;
    end else if (hx < ROT_SH_W'(SAT_MIN)) begin
      ox = SAT_MIN;
    end else begin
      ox = hx[VEC_W-1:0];
      cx = 1'b0;
    end
    if (hy > ROT_SH_W'(SAT_MAX)) begin
      oy = SAT_MAX;
    end else if (hy < ROT_SH_W'(SAT_MIN)) begin
      oy = SAT_MIN;
    end else begin
      oy = hy[VEC_W-1:0];
      cy = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (r2) begin
      dst.rot_x     <= ox;
      dst.rot_y     <= oy;
      dst.saturated <= cx || cy;
    end
  end
endmodule

FILE: design/vector_rotation_2d_core.sv
// top level: 2d vector rotation with pipelined taylor series sine and cosine
//
//   channel   dir   payload                           handshake
//   in_vec    in    vec_x, vec_y, angle (16b each)    valid / ready
//   out_vec   out   rot_x, rot_y (16b), saturated     valid / ready
//
// one request per cycle sustained while out_vec is ready; the pipeline has
// two register stages per series term plus angle prep and two output stages
// every stage holds its own valid bit; a stage loads when empty or when the
// next one moves, so bubbles close up while the output is stalled
// rst is synchronous and clears the valid bits only
`timescale 1ns / 1ps
module vector_rotation_2d_core import vrot_pkg::*; #(
  parameter int SERIES_TERMS = SERIES_TERMS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  vrot_in_if.sink    in_vec,
  vrot_out_if.source out_vec
);
  localparam int NT = SERIES_TERMS - 1;

  logic       v   [NT+1];
  logic       r   [NT+1];
  vrot_data_t d   [NT+1];

  vrot_prep u_prep (
    .clk   (clk),
    .rst   (rst),
    .v_in  (in_vec.valid),
    .r_in  (in_vec.ready),
    .vx    (in_vec.vec_x),
    .vy    (in_vec.vec_y),
    .ang   (in_vec.angle),
    .v_out (v[0]),
    .r_out (r[0]),
    .d_out (d[0])
  );

  for (genvar i = 0; i < NT; i++) begin : g_term
    vrot_term #(.K(i + 1)) u_term (
      .clk   (clk),
      .rst   (rst),
      .v_in  (v[i]),
      .r_in  (r[i]),
      .d_in  (d[i]),
      .v_out (v[i+1]),
      .r_out (r[i+1]),
      .d_out (d[i+1])
    );
  end

  vrot_out u_out (
    .clk  (clk),
    .rst  (rst),
    .v_in (v[NT]),
    .r_in (r[NT]),
    .d_in (d[NT]),
    .dst  (out_vec)
  );
endmodule

FILE: design/vrot_checker.sv
// port checker for the rotation core, bound to the top level
`timescale 1ns / 1ps
module vrot_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] rot_x,
  input logic [15:0] rot_y,
  input logic        saturated
);
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(rot_x) && $stable(rot_y)
      && $stable(saturated))
    else $error("stalled result changed");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> rot_x == 16'h7fff || rot_x == 16'h8000
      || rot_y == 16'h7fff || rot_y == 16'h8000)
    else $error("saturated flag without clipped value");
endmodule

bind vector_rotation_2d_core vrot_checker u_vrot_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_vec.valid),
  .in_ready  (in_vec.ready),
  .out_valid (out_vec.valid),
  .out_ready (out_vec.ready),
  .rot_x     (out_vec.rot_x),
  .rot_y     (out_vec.rot_y),
  .saturated (out_vec.saturated)
);

FILE: tb/sv/tb_top.sv
// testbench top: directed and random rotation requests checked against a fixed point predictor
`timescale 1ns / 1ps
module tb_top;
  import vrot_pkg::*;

  typedef struct {
    logic signed [15:0] rx;
    logic signed [15:0] ry;
    logic               sat;
  } rot_res_t;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 2 * (SERIES_TERMS_DEF - 1) + 3 + 20;
  localparam int HOLD_CYCLES    = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;

  vrot_in_if  in_if();
  vrot_out_if out_if();

  vector_rotation_2d_core dut (
    .clk     (clk),
    .rst     (rst),
    .in_vec  (in_if.sink),
    .out_vec (out_if.source)
  );

  rot_res_t rot_expect_q[$];
  int       snd_idle_pct = 0;
  int       rcv_idle_pct = 0;
  int       hold_req = 0;
  int       err_cnt = 0;
  int       sent_cnt = 0;
  int       got_cnt = 0;
  int       sat_cnt = 0;
  int       quiet_cnt = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  // sine and cosine series in q.16, term recurrence with floor truncation
  function automatic longint trig_series(longint start, longint a2, int off);
    longint term;
    longint sum;
    longint r;
    term = start;
    sum  = start;
    for (int k = 1; k < SERIES_TERMS_DEF; k++) begin
      r = (longint'(1) <<< 32) / longint'((2 * k + off - 1) * (2 * k + off));
      term = ((term * a2) >>> 16) * r >>> 32;
      term = -term;
      sum += term;
    end
    return sum;
  endfunction

  function automatic logic signed [15:0] clip16(longint v, inout logic sat);
    if (v > 32767) begin
      sat = 1'b1;
      return 16'sh7fff;
    end
    if (v < -32768) begin
      sat = 1'b1;
      return 16'sh8000;
    end
    return 16'(v);
  endfunction

  function automatic rot_res_t rotate_vec(logic signed [15:0] x, logic signed [15:0] y,
                                          logic signed [15:0] ang);
    rot_res_t res;
    longint   a;
    longint   a2;
    longint   s;
    longint   c;
    logic     sat;
    a   = longint'(ang) * 8;
    a2  = (a * a) >>> 16;
    s   = trig_series(a, a2, 1);
    c   = trig_series(65536, a2, 0);
    sat = 1'b0;
    res.rx  = clip16((longint'(x) * c - longint'(y) * s) >>> 16, sat);
    res.ry  = clip16((longint'(x) * s + longint'(y) * c) >>> 16, sat);
    res.sat = sat;
    return res;
  endfunction

  task automatic send_req(logic signed [15:0] x, logic signed [15:0] y,
                          logic signed [15:0] ang);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.vec_x <= x;
    in_if.vec_y <= y;
    in_if.angle <= ang;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    rot_expect_q.push_back(rotate_vec(x, y, ang));
    sent_cnt++;
  endtask

  // response checker and ready generator
  initial begin
    rot_res_t exp_r;
    int       hold_left;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_if.valid && out_if.ready) begin
        got_cnt++;
        if (out_if.saturated) sat_cnt++;
        if (rot_expect_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) $display("unexpected result rot_x=%0d rot_y=%0d sat=%0b",
                                      out_if.rot_x, out_if.rot_y, out_if.saturated);
        end else begin
          exp_r = rot_expect_q.pop_front();
          if (out_if.rot_x !== exp_r.rx || out_if.rot_y !== exp_r.ry ||
              out_if.saturated !== exp_r.sat) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("mismatch: exp x=%0d y=%0d sat=%0b got x=%0d y=%0d sat=%0b",
                       exp_r.rx, exp_r.ry, exp_r.sat,
                       out_if.rot_x, out_if.rot_y, out_if.saturated);
          end
        end
      end
      if (hold_req != 0 && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // watchdog on cycles with no handshake on either the input or the output channel
  initial begin
    forever begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || rst)
        quiet_cnt = 0;
      else
        quiet_cnt++;
      if (quiet_cnt >= WATCHDOG_LIMIT) begin
        $display("timeout after %0d idle cycles", quiet_cnt);
        $display("vector_rotation_2d_core regression: fail");
        $finish;
      end
    end
  end

  task automatic test_directed();
    logic signed [15:0] pi_q = 16'sd25736;
    send_req(16'sd4096, 16'sd0, 16'sd0);
    send_req(16'sd4096, 16'sd0, pi_q);
    send_req(16'sd4096, 16'sd0, -pi_q);
    send_req(16'sd0, 16'sd4096, 16'sd12868);
    send_req(16'sd4096, 16'sd4096, -16'sd12868);
    send_req(16'sh7fff, 16'sh7fff, 16'sd6434);
    send_req(16'sh8000, 16'sh8000, -16'sd6434);
    send_req(16'sh7fff, 16'sh8000, pi_q);
    send_req(16'sh8000, 16'sh7fff, 16'sd0);
    send_req(16'sh7fff, 16'sh7fff, 16'sd0);
    send_req(16'sd0, 16'sd0, pi_q);
    send_req(16'sd1, -16'sd1, 16'sd1);
    send_req(-16'sd1, -16'sd1, -16'sd1);
    send_req(16'sd4096, 16'sd0, 16'sh7fff);
    send_req(16'sd4096, 16'sd0, 16'sh8000);
    send_req(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_req(16'sh8000, 16'sh8000, 16'sh8000);
    send_req(16'sd2048, -16'sd2048, 16'sd25000);
    send_req(16'sh5555, 16'shaaaa, 16'sh5555);
    send_req(16'shaaaa, 16'sh5555, 16'shaaaa);
  endtask

  task automatic test_random(int n, int s_idle, int r_idle);
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] ang;
    snd_idle_pct = s_idle;
    rcv_idle_pct = r_idle;
    repeat (n) begin
      x = 16'($urandom);
      y = 16'($urandom);
      if ($urandom_range(3) == 0) begin
        x = 16'($signed($urandom_range(8192)) - 4096);
        y = 16'($signed($urandom_range(8192)) - 4096);
      end
      if ($urandom_range(9) < 7) ang = 16'($signed($urandom_range(51472)) - 25736);
      else ang = 16'($urandom);
      send_req(x, y, ang);
    end
  endtask

  task automatic test_backpressure();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_req = 1;
    repeat (80) send_req(16'($urandom), 16'($urandom),
                         16'($signed($urandom_range(51472)) - 25736));
  endtask

  initial begin
    in_if.valid <= 1'b0;
    in_if.vec_x <= '0;
    in_if.vec_y <= '0;
    in_if.angle <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(420, 15, 82);
    test_random(420, 82, 15);
    test_random(420, 0, 0);
    test_backpressure();
    in_if.valid <= 1'b0;
    rcv_idle_pct = 0;
    while (rot_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d rotation requests, checked %0d results, %0d saturated",
             sent_cnt, got_cnt, sat_cnt);
    $display("covered extremes, out of range angles, three idle mixes and a long output stall");
    if (err_cnt == 0 && rot_expect_q.size() == 0) begin
      $display("vector_rotation_2d_core regression: pass");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("vector_rotation_2d_core regression: fail");
    end
    $finish;
  end

endmodule
